### src/atl_pkg.sv
// Shared types, codes and reset contents of the alignment table lookup block.
package atl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int WIDTH_W = 24;
   localparam int ALIGN_W = 16;
   localparam int INT_RESET_COUNT = 5;
   localparam int FLOAT_RESET_COUNT = 4;

   localparam logic ACTION_SET = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   localparam logic [1:0] SEL_INT = 2'd0;
   localparam logic [1:0] SEL_FLOAT = 2'd1;
   localparam logic [1:0] SEL_POINTER = 2'd2;

   localparam logic REG_POINTER_ABI = 1'b0;
   localparam logic REG_POINTER_PREF = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic [ALIGN_W-1:0] abi;
      logic [ALIGN_W-1:0] pref;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic execute;
   } cmd_type;

   function automatic entry_type make_entry(input int width, input int align);
      entry_type e;
      e.width = WIDTH_W'(width);
      e.abi = ALIGN_W'(align);
      e.pref = ALIGN_W'(align);
      return e;
   endfunction

   function automatic entry_type reset_entry(input logic is_float, input int idx);
      entry_type e;
      e = '0;
      if (is_float) begin
         case (idx)
            0: e = make_entry(16, 2);
            1: e = make_entry(32, 4);
            2: e = make_entry(64, 8);
            3: e = make_entry(128, 16);
            default: e = '0;
         endcase
      end else begin
         case (idx)
            0: e = make_entry(1, 1);
            1: e = make_entry(8, 1);
            2: e = make_entry(16, 2);
            3: e = make_entry(32, 4);
            4: e = make_entry(64, 8);
            default: e = '0;
         endcase
      end
      return e;
   endfunction

endpackage

### src/atl_table.sv
// One sorted alignment table with parallel compare, in-place update and shifting insert.
module atl_table #(
   parameter int TABLE_DEPTH = atl_pkg::DEFAULT_TABLE_DEPTH,
   parameter bit FLOAT_TABLE = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [atl_pkg::WIDTH_W-1:0]   key,
   input  logic [atl_pkg::ALIGN_W-1:0]   abi,
   input  logic [atl_pkg::ALIGN_W-1:0]   pref,
   input  logic                          want_abi,
   output logic [atl_pkg::ALIGN_W-1:0]   lookup_align,
   output logic                          refused
);
   import atl_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   entry_type              entry_ff [TABLE_DEPTH];
   entry_type              entry_in [TABLE_DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [TABLE_DEPTH-1:0] valid;
   logic [TABLE_DEPTH-1:0] below;
   logic [TABLE_DEPTH-1:0] prev_below;
   logic [TABLE_DEPTH-1:0] equal;
   logic [TABLE_DEPTH-1:0] pick;
   logic                   all_below;
   logic                   any_match;
   logic                   full;
   logic                   insert;
   entry_type              new_entry;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid[i] = CNT_W'(i) < count_ff;
         below[i] = valid[i] && (entry_ff[i].width < key);
         equal[i] = valid[i] && (entry_ff[i].width == key);
      end
      prev_below[0] = 1'b1;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         prev_below[i] = below[i-1];
      end
   end

   assign all_below = ~|(valid & ~below);
   assign any_match = |equal;
   assign full = count_ff == CNT_W'(TABLE_DEPTH);
   assign insert = wr_en && !any_match && !full;
   assign refused = !any_match && full;

   assign new_entry.width = key;
   assign new_entry.abi = abi;
   assign new_entry.pref = pref;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (wr_en && equal[i]) begin
            entry_in[i].abi = abi;
            entry_in[i].pref = pref;
         end else if (insert && !below[i]) begin
            if (prev_below[i]) begin
               entry_in[i] = new_entry;
            end else begin
               entry_in[i] = entry_ff[i-1];
            end
         end
      end
      count_in = insert ? count_ff + CNT_W'(1) : count_ff;
   end

   always_comb begin
      logic [ALIGN_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pick[i] = (valid[i] && !below[i] && prev_below[i])
                   || (all_below && (CNT_W'(i + 1) == count_ff));
         if (pick[i]) begin
            acc = acc | (want_abi ? entry_ff[i].abi : entry_ff[i].pref);
         end
      end
      lookup_align = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_ff[i] <= reset_entry(FLOAT_TABLE, i);
         end
         count_ff <= FLOAT_TABLE ? CNT_W'(FLOAT_RESET_COUNT) : CNT_W'(INT_RESET_COUNT);
      end else begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
         count_ff <= count_in;
      end
   end

endmodule

### src/atl_datapath.sv
// Request registers, pointer registers, both tables and the response payload register.
module atl_datapath #(
   parameter int TABLE_DEPTH = atl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  atl_pkg::cmd_type              cmd,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [atl_pkg::ALIGN_W-1:0]   csr_wdata,
   input  logic                          req_action,
   input  logic [1:0]                    req_table_select,
   input  logic [atl_pkg::WIDTH_W-1:0]   req_type_bits,
   input  logic [atl_pkg::ALIGN_W-1:0]   req_abi_align,
   input  logic [atl_pkg::ALIGN_W-1:0]   req_pref_align,
   input  logic                          req_want_abi,
   output logic [atl_pkg::ALIGN_W-1:0]   rsp_alignment,
   output logic                          rsp_status
);
   import atl_pkg::*;

   logic               action_ff;
   logic [1:0]         select_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [ALIGN_W-1:0] abi_ff;
   logic [ALIGN_W-1:0] pref_ff;
   logic               want_abi_ff;
   logic [ALIGN_W-1:0] ptr_abi_ff;
   logic [ALIGN_W-1:0] ptr_pref_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [ALIGN_W-1:0] align_in;
   logic               status_ff;
   logic               status_in;
   logic               int_wr;
   logic               float_wr;
   logic [ALIGN_W-1:0] int_align;
   logic [ALIGN_W-1:0] float_align;
   logic               int_refused;
   logic               float_refused;

   assign int_wr = cmd.execute && (action_ff == ACTION_SET) && (select_ff == SEL_INT);
   assign float_wr = cmd.execute && (action_ff == ACTION_SET) && (select_ff == SEL_FLOAT);

   atl_table #(.TABLE_DEPTH(TABLE_DEPTH), .FLOAT_TABLE(1'b0)) u_int_table (
      .clock(clock), .reset(reset), .wr_en(int_wr), .key(width_ff), .abi(abi_ff),
      .pref(pref_ff), .want_abi(want_abi_ff), .lookup_align(int_align),
      .refused(int_refused)
   );

   atl_table #(.TABLE_DEPTH(TABLE_DEPTH), .FLOAT_TABLE(1'b1)) u_float_table (
      .clock(clock), .reset(reset), .wr_en(float_wr), .key(width_ff), .abi(abi_ff),
      .pref(pref_ff), .want_abi(want_abi_ff), .lookup_align(float_align),
      .refused(float_refused)
   );

   always_comb begin
      align_in = '0;
      status_in = STATUS_DONE;
      if (action_ff == ACTION_LOOKUP) begin
         case (select_ff)
            SEL_INT: align_in = int_align;
            SEL_FLOAT: align_in = float_align;
            default: align_in = want_abi_ff ? ptr_abi_ff : ptr_pref_ff;
         endcase
      end else begin
         case (select_ff)
            SEL_INT: status_in = int_refused ? STATUS_FULL : STATUS_DONE;
            SEL_FLOAT: status_in = float_refused ? STATUS_FULL : STATUS_DONE;
            default: status_in = STATUS_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_abi_ff <= ALIGN_W'(8);
         ptr_pref_ff <= ALIGN_W'(8);
      end else if (csr_we) begin
         case (csr_index)
            REG_POINTER_ABI: ptr_abi_ff <= csr_wdata;
            REG_POINTER_PREF: ptr_pref_ff <= csr_wdata;
            default: ptr_abi_ff <= ptr_abi_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         select_ff <= req_table_select;
         width_ff <= req_type_bits;
         abi_ff <= req_abi_align;
         pref_ff <= req_pref_align;
         want_abi_ff <= req_want_abi;
      end
      if (cmd.execute) begin
         align_ff <= align_in;
         status_ff <= status_in;
      end
   end

   assign rsp_alignment = align_ff;
   assign rsp_status = status_ff;

endmodule

### src/atl_control.sv
// Controller state machine that sequences capture and execution of each request.
module atl_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output atl_pkg::cmd_type cmd
);
   import atl_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign req_ready = state_ff == ST_IDLE;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd.load_req = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/alignment_table_lookup.sv
// Top level of the alignment table lookup block.
// Each request is first registered, then executed: a parallel compare across every
// entry of the chosen table finds the sorted position, the lookup, overwrite or
// shifting insert completes (a pointer select uses a pointer register) and the
// response register loads. A new request is accepted only when idle, after the last
// one has executed; a response that is not taken delays the next one's execute.
// Both tables reload their default entries on reset, so no clearing time follows.
module alignment_table_lookup #(
   parameter int TABLE_DEPTH = atl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [atl_pkg::ALIGN_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [1:0]                    req_table_select,
   input  logic [atl_pkg::WIDTH_W-1:0]   req_type_bits,
   input  logic [atl_pkg::ALIGN_W-1:0]   req_abi_align,
   input  logic [atl_pkg::ALIGN_W-1:0]   req_pref_align,
   input  logic                          req_want_abi,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [atl_pkg::ALIGN_W-1:0]   rsp_alignment,
   output logic                          rsp_status
);
   import atl_pkg::*;

   cmd_type cmd;

   atl_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd)
   );

   atl_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_action(req_action), .req_table_select(req_table_select),
      .req_type_bits(req_type_bits), .req_abi_align(req_abi_align),
      .req_pref_align(req_pref_align), .req_want_abi(req_want_abi),
      .rsp_alignment(rsp_alignment), .rsp_status(rsp_status)
   );

endmodule

### src/atl_checker.sv
// Port-level checks of the alignment table lookup block and their bind.
module atl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [atl_pkg::ALIGN_W-1:0]   rsp_alignment,
   input logic                          rsp_status
);

   // A response that is not taken holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alignment)
                                  && $stable(rsp_status))
      else $error("response changed while stalled");

   // An accepted request occupies the block in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still executing");

   // With the response side free, a busy cycle ends with a response and ready again.
   a_exec_completes: assert property (@(posedge clock) disable iff (reset)
      !req_ready && !(rsp_valid && !rsp_ready) |=> req_ready && rsp_valid)
      else $error("request did not complete in its execute cycle");

   // A new response appears only at the end of a busy cycle.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response produced without an executing request");

endmodule

bind alignment_table_lookup atl_checker u_atl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_alignment(rsp_alignment),
   .rsp_status(rsp_status)
);
